@@ design/svpwm_pkg.sv @@
package svpwm_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 8;
    localparam int SINE_LEN       = 1 << SINE_ADDR_BITS;

    localparam int IDX_BITS   = SINE_ADDR_BITS + 2;
    localparam int IDX_SHIFT  = PHASE_BITS - SINE_ADDR_BITS - 1;
    localparam int RECIP3_SH  = 17;
    localparam logic [15:0] RECIP3 = 16'd43691;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    localparam logic [1:0] REG_CARRIER_PERIOD   = 2'd0;
    localparam logic [1:0] REG_MODULATION_INDEX = 2'd1;
    localparam logic [1:0] REG_PHASE_STEP       = 2'd2;

    typedef logic [63:0] taylor_div_t [1:8];
    localparam taylor_div_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210, 64'd272};

    typedef logic [15:0] sine_rom_t [SINE_LEN];

    function automatic logic [15:0] sine_q16(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] v;
        sum  = x;
        term = x;
        for (int k = 1; k <= 8; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k];
            if ((k % 2) == 1)
                sum = (sum > term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        v = (sum + 64'd8192) >> 14;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic sine_rom_t sine_rom_build();
        sine_rom_t t;
        for (int i = 0; i < SINE_LEN; i++)
        begin
            t[i] = sine_q16((PI_Q30 * 64'(i)) >> (SINE_ADDR_BITS + 1));
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = sine_rom_build();

endpackage

@@ design/svpwm_compare_generator.sv @@
// After the input transfer the FSM steps LOOK_M, MUL_M, LOOK_N, MUL_N, ZERO,
// CMP_A, CMP_B, CMP_C, DONE; a new tick is taken only in IDLE. A single shared
// 17x17 multiplier forms both active duties and the three compare values in turn.
// A finished result waits in the output register while the next tick is taken.
// Reset: phase accumulator cleared, registers take their default values
// (period 7500, depth 62259, step 21474836); the sine table is constant.
module svpwm_compare_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        advance,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] compare_a,
    output logic [15:0] compare_b,
    output logic [15:0] compare_c,
    output logic [2:0]  sector
);

    localparam int P = svpwm_pkg::PHASE_BITS;
    localparam int A = svpwm_pkg::SINE_ADDR_BITS;
    localparam int W = svpwm_pkg::IDX_BITS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOOK_M = 4'd1;
    localparam logic [3:0] ST_MUL_M  = 4'd2;
    localparam logic [3:0] ST_LOOK_N = 4'd3;
    localparam logic [3:0] ST_MUL_N  = 4'd4;
    localparam logic [3:0] ST_ZERO   = 4'd5;
    localparam logic [3:0] ST_CMP_A  = 4'd6;
    localparam logic [3:0] ST_CMP_B  = 4'd7;
    localparam logic [3:0] ST_CMP_C  = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [15:0] carrier_period_reg;
    logic [16:0] modulation_index_reg;
    logic [31:0] phase_step_reg;
    logic [31:0] phase_acc_reg;
    logic        out_valid_reg;

    logic [2:0]   sec_reg;
    logic [P-1:0] frac_reg;
    logic [15:0]  sine_reg;
    logic [15:0]  dm_reg, dn_reg;
    logic [16:0]  duty_a_reg, duty_b_reg, duty_c_reg;
    logic [15:0]  comp_a_reg, comp_b_reg, comp_c_reg;
    logic [15:0]  compare_a_reg, compare_b_reg, compare_c_reg;
    logic [2:0]   sector_reg;

    logic [P-1:0]  phase_w;
    logic [P+2:0]  scaled;
    logic [P:0]    f_sel;
    logic [W-1:0]  idx_v;
    logic [W+15:0] idx_prod;
    logic [A-1:0]  rom_idx;
    logic [16:0]   m_sat;
    logic [15:0]   period_eff;
    logic [16:0]   mul_a, mul_b;
    logic [33:0]   mul_p;
    logic [16:0]   cmp_raw;
    logic [15:0]   cmp_sat;
    logic [16:0]   sum_mn;
    logic [15:0]   d0;
    logic [16:0]   lo, mid_m, mid_n, hi;
    logic          in_xfer, out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign compare_a = compare_a_reg;
    assign compare_b = compare_b_reg;
    assign compare_c = compare_c_reg;
    assign sector    = sector_reg;

    assign phase_w = phase_acc_reg[31 -: P];
    assign scaled  = ({3'b000, phase_w} << 2) + ({3'b000, phase_w} << 1);

    assign f_sel    = (state_reg == ST_LOOK_M) ? (((P+1)'(1) << P) - {1'b0, frac_reg})
                                               : {1'b0, frac_reg};
    assign idx_v    = f_sel[P -: W];
    assign idx_prod = (W+16)'(idx_v) * (W+16)'(svpwm_pkg::RECIP3);
    assign rom_idx  = idx_prod[svpwm_pkg::RECIP3_SH +: A];

    assign m_sat      = (modulation_index_reg > svpwm_pkg::ONE_Q16) ? svpwm_pkg::ONE_Q16
                                                                    : modulation_index_reg;
    assign period_eff = (carrier_period_reg < 16'd2) ? 16'd2 : carrier_period_reg;

    always_comb
    begin
        case (state_reg)
            ST_MUL_M, ST_MUL_N:
            begin
                mul_a = m_sat;
                mul_b = {1'b0, sine_reg};
            end
            ST_CMP_A:
            begin
                mul_a = duty_a_reg;
                mul_b = {1'b0, period_eff};
            end
            ST_CMP_B:
            begin
                mul_a = duty_b_reg;
                mul_b = {1'b0, period_eff};
            end
            default:
            begin
                mul_a = duty_c_reg;
                mul_b = {1'b0, period_eff};
            end
        endcase
    end

    assign mul_p   = 34'(mul_a) * 34'(mul_b);
    assign cmp_raw = mul_p[32:16];

    always_comb
    begin
        if (cmp_raw == 17'd0)
            cmp_sat = 16'd1;
        else if (cmp_raw >= {1'b0, period_eff})
            cmp_sat = period_eff - 16'd1;
        else
            cmp_sat = cmp_raw[15:0];
    end

    assign sum_mn = {1'b0, dm_reg} + {1'b0, dn_reg};
    assign d0     = (sum_mn >= svpwm_pkg::ONE_Q16) ? 16'd0
                                                   : 16'((svpwm_pkg::ONE_Q16 - sum_mn) >> 1);
    assign lo     = {1'b0, d0};
    assign mid_m  = {1'b0, d0} + {1'b0, dm_reg};
    assign mid_n  = {1'b0, d0} + {1'b0, dn_reg};
    assign hi     = mid_m + {1'b0, dn_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_xfer) state_next = ST_LOOK_M;
            ST_LOOK_M: state_next = ST_MUL_M;
            ST_MUL_M:  state_next = ST_LOOK_N;
            ST_LOOK_N: state_next = ST_MUL_N;
            ST_MUL_N:  state_next = ST_ZERO;
            ST_ZERO:   state_next = ST_CMP_A;
            ST_CMP_A:  state_next = ST_CMP_B;
            ST_CMP_B:  state_next = ST_CMP_C;
            ST_CMP_C:  state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            carrier_period_reg   <= 16'd7500;
            modulation_index_reg <= 17'd62259;
            phase_step_reg       <= 32'd21474836;
            phase_acc_reg        <= 32'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    svpwm_pkg::REG_CARRIER_PERIOD:   carrier_period_reg   <= cfg_data[15:0];
                    svpwm_pkg::REG_MODULATION_INDEX: modulation_index_reg <= cfg_data[16:0];
                    svpwm_pkg::REG_PHASE_STEP:       phase_step_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer && advance)
                phase_acc_reg <= phase_acc_reg + phase_step_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sec_reg  <= scaled[P+2:P];
                frac_reg <= scaled[P-1:0];
            end
            ST_LOOK_M, ST_LOOK_N: sine_reg <= svpwm_pkg::SINE_ROM[rom_idx];
            ST_MUL_M:             dm_reg   <= mul_p[31:16];
            ST_MUL_N:             dn_reg   <= mul_p[31:16];
            ST_ZERO:
            begin
                case (sec_reg)
                    svpwm_pkg::SEC_0:
                    begin
                        duty_a_reg <= lo;    duty_b_reg <= mid_m; duty_c_reg <= hi;
                    end
                    svpwm_pkg::SEC_1:
                    begin
                        duty_a_reg <= mid_n; duty_b_reg <= lo;    duty_c_reg <= hi;
                    end
                    svpwm_pkg::SEC_2:
                    begin
                        duty_a_reg <= hi;    duty_b_reg <= lo;    duty_c_reg <= mid_m;
                    end
                    svpwm_pkg::SEC_3:
                    begin
                        duty_a_reg <= hi;    duty_b_reg <= mid_n; duty_c_reg <= lo;
                    end
                    svpwm_pkg::SEC_4:
                    begin
                        duty_a_reg <= mid_m; duty_b_reg <= hi;    duty_c_reg <= lo;
                    end
                    default:
                    begin
                        duty_a_reg <= lo;    duty_b_reg <= hi;    duty_c_reg <= mid_n;
                    end
                endcase
            end
            ST_CMP_A: comp_a_reg <= cmp_sat;
            ST_CMP_B: comp_b_reg <= cmp_sat;
            ST_CMP_C: comp_c_reg <= cmp_sat;
            default: ;
        endcase
        if (out_load)
        begin
            compare_a_reg <= comp_a_reg;
            compare_b_reg <= comp_b_reg;
            compare_c_reg <= comp_c_reg;
            sector_reg    <= sec_reg + 3'd1;
        end
    end

endmodule
